/* design/mqsb_pkg.sv */
package mqsb_pkg;

    localparam int ENTRIES    = 16;
    localparam int NUM_QUEUES = 4;
    localparam int DATA_BITS  = 32;

    localparam int SLOT_BITS = $clog2(ENTRIES);
    localparam int PTR_BITS  = $clog2(ENTRIES + 1);
    localparam int QID_BITS  = 2;
    localparam int OUT_BITS  = 32;
    localparam int STAT_BITS = 2;

    // Null pointer: one past the last slot
    localparam logic [PTR_BITS-1:0] NIL_PTR = PTR_BITS'(ENTRIES);

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;

    typedef logic [PTR_BITS-1:0] ptr_t;

    typedef struct packed {
        logic load;
        logic exec;
    } mqsb_cmd_t;

    function automatic logic is_slot(input ptr_t p);
        return p < NIL_PTR;
    endfunction

endpackage

/* design/multi_queue_shared_buffer.sv */
// Four FIFO queues sharing a 16-slot payload store, linked per slot, with
// free slots kept on a free list. Raise start with kind, queue_id and data_in
// while busy is low; the command is taken at that edge and busy stays high
// for one cycle. Every command yields one result once it has passed the EXEC
// state and the done register: done is high for exactly one cycle with
// data_out and status valid, and the receiver cannot stall it, so capture it
// then. A new command may be issued in the same cycle that done is shown; no
// command is taken while busy is high. The result is set by the registered
// read of the payload memory followed by the pointer and link update. Status
// is 0 ok, 1 store full (enqueue refused), 2 queue empty (dequeue refused);
// data_out is zero except on a successful dequeue.
module multi_queue_shared_buffer
    import mqsb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [QID_BITS-1:0]         queue_id,
    input  logic signed [OUT_BITS-1:0]  data_in,
    output logic                        done,
    output logic signed [OUT_BITS-1:0]  data_out,
    output logic [STAT_BITS-1:0]        status
);

    mqsb_cmd_t cmd;

    mqsb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    mqsb_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .kind     (kind),
        .queue_id (queue_id),
        .data_in  (data_in),
        .data_out (data_out),
        .status   (status)
    );

endmodule

/* design/mqsb_ctrl.sv */
module mqsb_ctrl
    import mqsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output mqsb_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

/* design/mqsb_datapath.sv */
module mqsb_datapath
    import mqsb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mqsb_cmd_t                   cmd,
    input  logic                        kind,
    input  logic [QID_BITS-1:0]         queue_id,
    input  logic signed [OUT_BITS-1:0]  data_in,
    output logic signed [OUT_BITS-1:0]  data_out,
    output logic [STAT_BITS-1:0]        status
);

    // Payload memory: no reset, read data registered
    logic [DATA_BITS-1:0] pay_mem [ENTRIES];
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 pay_we;
    logic [SLOT_BITS-1:0] pay_waddr;
    logic [SLOT_BITS-1:0] pay_raddr;

    ptr_t link_reg [ENTRIES];
    ptr_t link_next [ENTRIES];
    ptr_t head_reg [NUM_QUEUES];
    ptr_t head_next [NUM_QUEUES];
    ptr_t tail_reg [NUM_QUEUES];
    ptr_t tail_next [NUM_QUEUES];
    ptr_t free_reg;
    ptr_t free_next;

    logic                 op_kind_reg;
    logic [QID_BITS-1:0]  op_q_reg;
    logic [DATA_BITS-1:0] op_data_reg;

    logic signed [OUT_BITS-1:0] data_out_reg;
    logic signed [OUT_BITS-1:0] data_out_next;
    logic [STAT_BITS-1:0]       status_reg;
    logic [STAT_BITS-1:0]       status_next;

    logic q_ok;
    ptr_t q_head;
    ptr_t q_tail;
    ptr_t slot;
    ptr_t nxt;

    assign pay_raddr = head_reg[queue_id][SLOT_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= op_data_reg;
        end
        if (cmd.load)
        begin
            rd_data_reg <= pay_mem[pay_raddr];
            op_kind_reg <= kind;
            op_q_reg    <= queue_id;
            op_data_reg <= DATA_BITS'(data_in);
        end
    end

    assign q_ok   = (int'(op_q_reg) < NUM_QUEUES);
    assign q_head = head_reg[op_q_reg];
    assign q_tail = tail_reg[op_q_reg];
    assign slot   = (op_kind_reg == KIND_ENQ) ? free_reg : q_head;
    assign nxt    = link_reg[slot[SLOT_BITS-1:0]];

    always_comb
    begin
        link_next     = link_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        data_out_next = '0;
        status_next   = ST_OK;
        pay_we        = 1'b0;
        pay_waddr     = slot[SLOT_BITS-1:0];
        if (op_kind_reg == KIND_ENQ)
        begin
            if (!q_ok || !is_slot(free_reg))
            begin
                status_next = ST_FULL;
            end
            else
            begin
                free_next = is_slot(nxt) ? nxt : NIL_PTR;
                if (!is_slot(q_head))
                begin
                    head_next[op_q_reg] = slot;
                end
                else if (is_slot(q_tail))
                begin
                    link_next[q_tail[SLOT_BITS-1:0]] = slot;
                end
                link_next[slot[SLOT_BITS-1:0]] = NIL_PTR;
                tail_next[op_q_reg]            = slot;
                pay_we                         = cmd.exec;
            end
        end
        else
        begin
            if (!q_ok || !is_slot(q_head))
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                head_next[op_q_reg]            = is_slot(nxt) ? nxt : NIL_PTR;
                link_next[slot[SLOT_BITS-1:0]] = free_reg;
                free_next                      = slot;
                data_out_next = OUT_BITS'($signed(rd_data_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                link_reg[i] <= (i == ENTRIES - 1) ? NIL_PTR : PTR_BITS'(i + 1);
            end
            for (int j = 0; j < NUM_QUEUES; j++)
            begin
                head_reg[j] <= NIL_PTR;
                tail_reg[j] <= NIL_PTR;
            end
            free_reg <= '0;
        end
        else if (cmd.exec)
        begin
            link_reg <= link_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            data_out_reg <= data_out_next;
            status_reg   <= status_next;
        end
    end

    assign data_out = data_out_reg;
    assign status   = status_reg;

endmodule

/* design/mqsb_checker.sv */
module mqsb_checker
    import mqsb_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic signed [OUT_BITS-1:0]  data_out,
    input logic [STAT_BITS-1:0]        status
);

    // Every accepted transfer yields its result on done, after the EXEC state and the done register
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result missing two cycles after transfer");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer");

    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("done without a command in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == ST_OK || status == ST_FULL || status == ST_EMPTY)
        else $error("undefined status code");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> data_out == '0)
        else $error("refused command returned nonzero data");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (.*);
